// ===== design/wlm_pkg.sv =====
// Shared types, constants and decode helpers for the linear memory unit.
// No dependencies; imported by every module of the block but wlm_ram.
package wlm_pkg;

  localparam int unsigned MAX_PAGES   = 4;
  localparam int unsigned RESET_PAGES = 1;
  localparam int unsigned PAGE_BITS   = 16;
  localparam int unsigned MEM_BYTES   = MAX_PAGES << PAGE_BITS;
  localparam int unsigned ADDR_W      = $clog2(MEM_BYTES);
  localparam int unsigned BANKS       = 8;
  localparam int unsigned BANK_W      = 3;
  localparam int unsigned ROW_W       = ADDR_W - BANK_W;
  localparam int unsigned ROWS        = MEM_BYTES / BANKS;
  localparam int unsigned PG_ROW_SH   = PAGE_BITS - BANK_W;
  localparam int unsigned PC_W        = $clog2(MAX_PAGES + 1);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned LIM_W       = PC_W + PAGE_BITS;
  localparam int unsigned END_W       = 34;

  // config register index (paddr bit 2)
  localparam logic REG_INIT_PAGES = 1'b0;

  // instruction codes
  localparam logic [4:0] F_I32_LOAD     = 5'd0;
  localparam logic [4:0] F_I64_LOAD     = 5'd1;
  localparam logic [4:0] F_F32_LOAD     = 5'd2;
  localparam logic [4:0] F_F64_LOAD     = 5'd3;
  localparam logic [4:0] F_I32_LOAD8_S  = 5'd4;
  localparam logic [4:0] F_I32_LOAD8_U  = 5'd5;
  localparam logic [4:0] F_I32_LOAD16_S = 5'd6;
  localparam logic [4:0] F_I32_LOAD16_U = 5'd7;
  localparam logic [4:0] F_I64_LOAD8_S  = 5'd8;
  localparam logic [4:0] F_I64_LOAD8_U  = 5'd9;
  localparam logic [4:0] F_I64_LOAD16_S = 5'd10;
  localparam logic [4:0] F_I64_LOAD16_U = 5'd11;
  localparam logic [4:0] F_I64_LOAD32_S = 5'd12;
  localparam logic [4:0] F_I64_LOAD32_U = 5'd13;
  localparam logic [4:0] F_I32_STORE    = 5'd14;
  localparam logic [4:0] F_I64_STORE    = 5'd15;
  localparam logic [4:0] F_F32_STORE    = 5'd16;
  localparam logic [4:0] F_F64_STORE    = 5'd17;
  localparam logic [4:0] F_I32_STORE8   = 5'd18;
  localparam logic [4:0] F_I32_STORE16  = 5'd19;
  localparam logic [4:0] F_I64_STORE8   = 5'd20;
  localparam logic [4:0] F_I64_STORE16  = 5'd21;
  localparam logic [4:0] F_I64_STORE32  = 5'd22;
  localparam logic [4:0] F_MEM_SIZE     = 5'd23;
  localparam logic [4:0] F_MEM_GROW     = 5'd24;
  localparam logic [4:0] F_MEM_FILL     = 5'd25;
  localparam logic [4:0] F_MEM_COPY     = 5'd26;

  typedef enum logic [2:0] {
    OP_LOAD, OP_STORE, OP_SIZE, OP_GROW, OP_FILL, OP_COPY, OP_NOP
  } op_e;

  typedef struct packed {
    logic [4:0]  func;
    logic [31:0] base_addr;
    logic [31:0] mem_offset;
    logic [63:0] store_value;
    logic [31:0] source_addr;
    logic [31:0] byte_count;
    logic [31:0] grow_pages;
  } in_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        out_of_bounds;
    logic        grow_failed;
  } res_t;

  // decoded command passed from front to back
  typedef struct packed {
    op_e              op;
    logic [4:0]       func;
    logic [3:0]       nbytes;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] src;
    logic [END_W-1:0] end_a;
    logic [END_W-1:0] end_b;
    logic [63:0]      data;
    logic [CNT_W-1:0] cnt;
    logic             cnt_zero;
    logic             grow_big;
    logic [PC_W-1:0]  grow_n;
  } cmd_t;

  function automatic logic [3:0] access_bytes(input logic [4:0] f);
    logic [3:0] n;
    n = 4'd0;
    unique case (f) inside
      F_I32_LOAD, F_F32_LOAD, F_I64_LOAD32_S, F_I64_LOAD32_U,
      F_I32_STORE, F_F32_STORE, F_I64_STORE32:                 n = 4'd4;
      F_I64_LOAD, F_F64_LOAD, F_I64_STORE, F_F64_STORE:        n = 4'd8;
      F_I32_LOAD8_S, F_I32_LOAD8_U, F_I64_LOAD8_S, F_I64_LOAD8_U,
      F_I32_STORE8, F_I64_STORE8:                              n = 4'd1;
      F_I32_LOAD16_S, F_I32_LOAD16_U, F_I64_LOAD16_S, F_I64_LOAD16_U,
      F_I32_STORE16, F_I64_STORE16:                            n = 4'd2;
      default:                                                 n = 4'd0;
    endcase
    return n;
  endfunction

  // extend raw little-endian bytes to the instruction's result type
  function automatic logic [63:0] load_format(input logic [4:0] f, input logic [63:0] v);
    logic [63:0] r;
    r = v;
    unique case (f) inside
      F_I32_LOAD, F_F32_LOAD, F_I64_LOAD32_U: r = {32'b0, v[31:0]};
      F_I32_LOAD8_S:                          r = {32'b0, {24{v[7]}}, v[7:0]};
      F_I32_LOAD8_U, F_I64_LOAD8_U:           r = {56'b0, v[7:0]};
      F_I32_LOAD16_S:                         r = {32'b0, {16{v[15]}}, v[15:0]};
      F_I32_LOAD16_U, F_I64_LOAD16_U:         r = {48'b0, v[15:0]};
      F_I64_LOAD8_S:                          r = {{56{v[7]}}, v[7:0]};
      F_I64_LOAD16_S:                         r = {{48{v[15]}}, v[15:0]};
      F_I64_LOAD32_S:                         r = {{32{v[31]}}, v[31:0]};
      default:                                r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== design/wlm_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module wlm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/wlm_front.sv =====
// Front end: decodes incoming words into commands and queues them (2 deep).
// Depends on wlm_pkg.
module wlm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  wlm_pkg::in_t  in_i,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i,
  output wlm_pkg::cmd_t cmd_o
);
  import wlm_pkg::*;

  cmd_t       dec;
  cmd_t       q_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  always_comb begin
    dec          = '0;
    dec.func     = in_i.func;
    dec.nbytes   = access_bytes(in_i.func);
    dec.data     = in_i.store_value;
    dec.src      = ADDR_W'(in_i.source_addr);
    dec.cnt      = CNT_W'(in_i.byte_count);
    dec.cnt_zero = (in_i.byte_count == '0);
    dec.grow_big = (in_i.grow_pages > 32'(MAX_PAGES));
    dec.grow_n   = PC_W'(in_i.grow_pages);
    dec.end_b    = END_W'(in_i.source_addr) + END_W'(in_i.byte_count);
    dec.addr     = ADDR_W'(in_i.base_addr);
    dec.end_a    = END_W'(in_i.base_addr) + END_W'(in_i.byte_count);
    unique case (in_i.func) inside
      [F_I32_LOAD:F_I64_LOAD32_U]: dec.op = OP_LOAD;
      [F_I32_STORE:F_I64_STORE32]: dec.op = OP_STORE;
      F_MEM_SIZE:                  dec.op = OP_SIZE;
      F_MEM_GROW:                  dec.op = OP_GROW;
      F_MEM_FILL:                  dec.op = OP_FILL;
      F_MEM_COPY:                  dec.op = OP_COPY;
      default:                     dec.op = OP_NOP;
    endcase
    if (dec.op == OP_LOAD || dec.op == OP_STORE) begin
      dec.addr  = ADDR_W'(in_i.base_addr + in_i.mem_offset);
      dec.end_a = END_W'(in_i.base_addr) + END_W'(in_i.mem_offset) + END_W'(dec.nbytes);
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) q_q[wptr_q] <= dec;
  end

endmodule

// ===== design/wlm_resq.sv =====
// Result queue, 2 deep, between the back end and the result port.
// Depends on wlm_pkg.
module wlm_resq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wlm_pkg::res_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output wlm_pkg::res_t data_o
);
  import wlm_pkg::*;

  res_t       q_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = q_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) q_q[wptr_q] <= data_i;
  end

endmodule

// ===== design/wlm_back.sv =====
// Back end: executes commands on eight byte-wide memory banks, owns page count
// and the clearing sweep. Depends on wlm_pkg and wlm_ram.
module wlm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_pages_i,
  input  logic          cmd_valid_i,
  input  wlm_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output wlm_pkg::res_t res_o
);
  import wlm_pkg::*;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_LD, S_FILL, S_CPRD, S_CPWR} state_e;

  state_e            state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [ROW_W:0]    clr_q, clr_d, clr_end_q, clr_end_d;
  cmd_t              cur_q, cur_d;
  logic [ADDR_W-1:0] dst_q, dst_d, src_q, src_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              desc_q, desc_d;
  logic [BANK_W-1:0] rbank_q, rbank_d;

  logic              bank_we    [BANKS];
  logic [ROW_W-1:0]  bank_waddr [BANKS];
  logic [7:0]        bank_wdata [BANKS];
  logic [ROW_W-1:0]  bank_raddr [BANKS];
  logic [7:0]        bank_rdata [BANKS];
  logic [ROW_W-1:0]  ls_row     [BANKS];
  logic [BANK_W-1:0] ls_k       [BANKS];

  logic [LIM_W-1:0]  limit;
  logic              in_a, in_b, grow_fail;
  logic [PC_W:0]     grow_sum;
  logic [63:0]       ld_val;
  logic [PC_W-1:0]   new_pc;
  logic [ROW_W:0]    lo_row, hi_row;

  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    wlm_ram #(.WIDTH(8), .DEPTH(ROWS)) u_ram (
      .clk_i  (clk_i),
      .we_i   (bank_we[g]),
      .waddr_i(bank_waddr[g]),
      .wdata_i(bank_wdata[g]),
      .raddr_i(bank_raddr[g]),
      .rdata_o(bank_rdata[g])
    );
  end

  assign limit     = {pc_q, {PAGE_BITS{1'b0}}};
  assign in_a      = cmd_i.end_a <= END_W'(limit);
  assign in_b      = cmd_i.end_b <= END_W'(limit);
  assign grow_sum  = {1'b0, pc_q} + {1'b0, cmd_i.grow_n};
  assign grow_fail = cmd_i.grow_big || (grow_sum > (PC_W+1)'(MAX_PAGES));
  assign new_pc    = (32'(cfg_pages_i) > MAX_PAGES) ? PC_W'(MAX_PAGES) : PC_W'(cfg_pages_i);
  assign lo_row    = (ROW_W+1)'(new_pc) << PG_ROW_SH;
  assign hi_row    = (ROW_W+1)'(pc_q) << PG_ROW_SH;

  // bank b holds byte k = b - a[2:0] of an access at a; row steps past a wrap
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      ls_k[b]   = BANK_W'(b) - cmd_i.addr[BANK_W-1:0];
      ls_row[b] = cmd_i.addr[ADDR_W-1:BANK_W]
                + ROW_W'(BANK_W'(b) < cmd_i.addr[BANK_W-1:0]);
    end
    for (int i = 0; i < BANKS; i++) begin
      ld_val[8*i +: 8] = bank_rdata[BANK_W'(BANK_W'(i) + cur_q.addr[BANK_W-1:0])];
    end
  end

  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    clr_d      = clr_q;
    clr_end_d  = clr_end_q;
    cur_d      = cur_q;
    dst_d      = dst_q;
    src_d      = src_q;
    rem_d      = rem_q;
    desc_d     = desc_q;
    rbank_d    = rbank_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    for (int b = 0; b < BANKS; b++) begin
      bank_we[b]    = 1'b0;
      bank_waddr[b] = ls_row[b];
      bank_wdata[b] = 8'(cmd_i.data >> {ls_k[b], 3'b000});
      bank_raddr[b] = ls_row[b];
    end

    unique case (state_q)
      S_CLR: begin
        for (int b = 0; b < BANKS; b++) begin
          bank_we[b]    = 1'b1;
          bank_waddr[b] = clr_q[ROW_W-1:0];
          bank_wdata[b] = 8'h00;
        end
        clr_d = clr_q + 1'b1;
        if (clr_d == clr_end_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          unique case (cmd_i.op)
            OP_LOAD: begin
              if (!in_a) begin
                res_push_o          = 1'b1;
                res_o.out_of_bounds = 1'b1;
              end else begin
                state_d = S_LD;
              end
            end
            OP_STORE: begin
              res_push_o = 1'b1;
              if (!in_a) begin
                res_o.out_of_bounds = 1'b1;
              end else begin
                for (int b = 0; b < BANKS; b++) begin
                  bank_we[b] = {1'b0, ls_k[b]} < cmd_i.nbytes;
                end
              end
            end
            OP_SIZE: begin
              res_push_o         = 1'b1;
              res_o.result_value = 64'(pc_q);
            end
            OP_GROW: begin
              res_push_o = 1'b1;
              if (grow_fail) begin
                res_o.result_value = {32'b0, 32'hFFFF_FFFF};
                res_o.grow_failed  = 1'b1;
              end else begin
                res_o.result_value = 64'(pc_q);
                pc_d               = PC_W'(grow_sum);
              end
            end
            OP_FILL: begin
              if (!in_a || cmd_i.cnt_zero) begin
                res_push_o          = 1'b1;
                res_o.out_of_bounds = !in_a;
              end else begin
                dst_d   = cmd_i.addr;
                rem_d   = cmd_i.cnt;
                state_d = S_FILL;
              end
            end
            OP_COPY: begin
              if (!in_a || !in_b || cmd_i.cnt_zero) begin
                res_push_o          = 1'b1;
                res_o.out_of_bounds = !in_a || !in_b;
              end else begin
                rem_d   = cmd_i.cnt;
                desc_d  = cmd_i.addr > cmd_i.src;
                // overlapping move toward higher addresses runs from the top
                if (cmd_i.addr > cmd_i.src) begin
                  dst_d = cmd_i.addr + ADDR_W'(cmd_i.cnt) - 1'b1;
                  src_d = cmd_i.src + ADDR_W'(cmd_i.cnt) - 1'b1;
                end else begin
                  dst_d = cmd_i.addr;
                  src_d = cmd_i.src;
                end
                state_d = S_CPRD;
              end
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      S_LD: begin
        res_push_o         = 1'b1;
        res_o.result_value = load_format(cur_q.func, ld_val);
        state_d            = S_IDLE;
      end
      S_FILL: begin
        bank_we[dst_q[BANK_W-1:0]]    = 1'b1;
        bank_waddr[dst_q[BANK_W-1:0]] = dst_q[ADDR_W-1:BANK_W];
        bank_wdata[dst_q[BANK_W-1:0]] = cur_q.data[7:0];
        dst_d = dst_q + 1'b1;
        rem_d = rem_q - 1'b1;
        if (rem_q == CNT_W'(1)) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_CPRD: begin
        bank_raddr[src_q[BANK_W-1:0]] = src_q[ADDR_W-1:BANK_W];
        rbank_d = src_q[BANK_W-1:0];
        src_d   = desc_q ? src_q - 1'b1 : src_q + 1'b1;
        state_d = S_CPWR;
      end
      S_CPWR: begin
        bank_we[dst_q[BANK_W-1:0]]    = 1'b1;
        bank_waddr[dst_q[BANK_W-1:0]] = dst_q[ADDR_W-1:BANK_W];
        bank_wdata[dst_q[BANK_W-1:0]] = bank_rdata[rbank_q];
        dst_d = desc_q ? dst_q - 1'b1 : dst_q + 1'b1;
        rem_d = rem_q - 1'b1;
        if (rem_q == CNT_W'(1)) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_CPRD;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // page count write; shrinking zeroes the dropped pages
    if (cfg_we_i) begin
      pc_d = new_pc;
      if (new_pc < pc_q) begin
        state_d = S_CLR;
        if (state_q == S_CLR) begin
          clr_d     = (lo_row < clr_d) ? lo_row : clr_d;
          clr_end_d = (hi_row > clr_end_q) ? hi_row : clr_end_q;
        end else begin
          clr_d     = lo_row;
          clr_end_d = hi_row;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      pc_q      <= PC_W'(RESET_PAGES);
      clr_q     <= '0;
      clr_end_q <= (ROW_W+1)'(ROWS);
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      clr_q     <= clr_d;
      clr_end_q <= clr_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    dst_q   <= dst_d;
    src_q   <= src_d;
    rem_q   <= rem_d;
    desc_q  <= desc_d;
    rbank_q <= rbank_d;
  end

endmodule

// ===== design/wasm_linear_memory_unit.sv =====
// Linear memory unit top: config register, front decode queue, back executor
// over 8 byte banks, result queue. Store/size/grow finish in the idle state,
// a load adds S_LD, fill writes its N bytes in turn and copy reads then writes
// each (one byte-bank port each way per cycle). Results pass the front and result
// queue registers, a load's also S_LD. Reset (async, active low): pages = 1, then
// a sweep zeroes all 32768 bank rows, one a cycle; shrinking sweeps 8192 per page.
module wasm_linear_memory_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input word queue
  input  logic          push,
  output logic          full,
  input  wlm_pkg::in_t  in_data_i,
  // result word queue
  output logic          empty,
  input  logic          pop,
  output wlm_pkg::res_t out_data_o,
  // APB config port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import wlm_pkg::*;

  logic [2:0] init_pages_q;
  logic       cfg_we;
  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;
  logic       res_push, res_full;
  res_t       res;

  // register at byte 0 (index = paddr[2]); pready tied high, no wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_INIT_PAGES);
  assign prdata = (paddr[2] == REG_INIT_PAGES) ? {29'b0, init_pages_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_pages_q <= 3'(RESET_PAGES);
    end else if (cfg_we) begin
      init_pages_q <= pwdata[2:0];
    end
  end

  // front: decode + 2-deep command queue; keeps accepting during back stalls until full
  wlm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_i       (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd)
  );

  // back: takes a command only when the result queue has room, so each
  // command's single result never meets a full queue
  wlm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_pages_i(pwdata[2:0]),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  wlm_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (out_data_o)
  );

  // a result is never dropped at the result queue
  a_no_res_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && res_full))
    else $error("result pushed into full queue");

  // grow failure carries all-ones low word and no fault
  a_grow_fail_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.grow_failed) |->
      (out_data_o.result_value == 64'h0000_0000_FFFF_FFFF && !out_data_o.out_of_bounds))
    else $error("malformed grow failure result");

  // a fault returns zero data
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.out_of_bounds) |->
      (out_data_o.result_value == 64'd0 && !out_data_o.grow_failed))
    else $error("fault result carries data");

endmodule
